// ===== design/crg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register codes and field helpers of the camera ray generator.
// No dependencies; the top level takes it in by wildcard import.
package crg_pkg;

  localparam int PIXEL_COORD_BITS_DEF = 12;

  localparam int CFG_DATA_W  = 60;
  localparam int CFG_INDEX_W = 3;
  localparam int FIELD_W     = 20;
  localparam int PSIZE_W     = 24;
  localparam int DIR_W       = 18;

  // Normalized magnitudes keep their leading one at bit NORM_TOP.
  localparam int NORM_TOP = 29;
  localparam int NORM_W   = 30;
  localparam int SUM_W    = 2 * NORM_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int QUO_W    = 17;
  localparam int ONE_Q16  = 65536;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_X       = 3'd0,
    REG_ROW_Y       = 3'd1,
    REG_ROW_Z       = 3'd2,
    REG_TRANSLATION = 3'd3,
    REG_PIXEL_SIZE  = 3'd4,
    REG_HALF_WIDTH  = 3'd5,
    REG_HALF_HEIGHT = 3'd6
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] ROW_X_RST = 60'h1000;
  localparam logic [CFG_DATA_W-1:0] ROW_Y_RST = 60'h100000000;
  localparam logic [CFG_DATA_W-1:0] ROW_Z_RST = 60'h10000000000000;
  localparam logic [PSIZE_W-1:0]    PSIZE_RST = 24'd13107;
  localparam logic [FIELD_W-1:0]    HALF_W_RST = 20'd4096;
  localparam logic [FIELD_W-1:0]    HALF_H_RST = 20'd3072;

  // Pick signed Q8.12 field j out of a packed 60-bit register.
  function automatic logic signed [FIELD_W-1:0] fld(input logic [CFG_DATA_W-1:0] r,
                                                    input logic [1:0] j);
    fld = $signed(r[j*FIELD_W +: FIELD_W]);
  endfunction

endpackage

// ===== design/camera_ray_generator_unit.sv =====
`timescale 1ns / 1ps
// Pinhole camera primary ray generator: pixel to view plane point, affine
// transform, normalization by pipelined square root and division. Uses crg_pkg.
//
// One pixel beat enters per clock and one ray beat leaves per clock unless a
// finished ray is held under out_stall. There are 8 front stages, 32 square root
// stages, 18 division stages and the output register; the root and quotient chains
// give one bit per stage. The whole pipeline holds while a finished ray waits under
// out_stall. The origin is the translation register itself. The user must write the
// registers only while no beat is in flight; the block itself does not enforce this.
module camera_ray_generator_unit import crg_pkg::*; #(
  parameter int PIXEL_COORD_BITS = PIXEL_COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [CFG_INDEX_W-1:0]        wr_index,
  input  logic [CFG_DATA_W-1:0]         wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PIXEL_COORD_BITS-1:0]   pixel_x,
  input  logic [PIXEL_COORD_BITS-1:0]   pixel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FIELD_W-1:0]     origin_x,
  output logic signed [FIELD_W-1:0]     origin_y,
  output logic signed [FIELD_W-1:0]     origin_z,
  output logic signed [DIR_W-1:0]       dir_x,
  output logic signed [DIR_W-1:0]       dir_y,
  output logic signed [DIR_W-1:0]       dir_z,
  output logic                          degenerate
);

  localparam int PB     = PIXEL_COORD_BITS;
  localparam int PROD_W = PB + 1 + PSIZE_W;
  localparam int OFF_W  = PROD_W - 8;
  localparam int WW     = OFF_W + 1;
  localparam int PRD_W  = WW + FIELD_W;
  localparam int D_W    = PRD_W + 2;
  localparam int MAG_W  = D_W;
  localparam int GRP    = (MAG_W + 7) / 8;
  localparam int GRP_W  = $clog2(GRP);
  localparam int PS_W   = GRP_W + 3;
  localparam int SQ_STEPS = ROOT_W;
  localparam int REM_W  = ROOT_W + 4;
  localparam int DEN_W  = ROOT_W + 1;
  localparam int DREM_W = DEN_W + 1;
  localparam int NUM_W  = NORM_W + QUO_W + 1;
  localparam int FRONT  = 8;

  // Configuration registers
  logic [CFG_DATA_W-1:0] inv_row_x, inv_row_y, inv_row_z, inv_translation;
  logic [PSIZE_W-1:0]    pixel_size;
  logic [FIELD_W-1:0]    half_width, half_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_row_x       <= ROW_X_RST;
      inv_row_y       <= ROW_Y_RST;
      inv_row_z       <= ROW_Z_RST;
      inv_translation <= '0;
      pixel_size      <= PSIZE_RST;
      half_width      <= HALF_W_RST;
      half_height     <= HALF_H_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_ROW_X:       inv_row_x       <= wr_data;
        REG_ROW_Y:       inv_row_y       <= wr_data;
        REG_ROW_Z:       inv_row_z       <= wr_data;
        REG_TRANSLATION: inv_translation <= wr_data;
        REG_PIXEL_SIZE:  pixel_size      <= wr_data[PSIZE_W-1:0];
        REG_HALF_WIDTH:  half_width      <= wr_data[FIELD_W-1:0];
        REG_HALF_HEIGHT: half_height     <= wr_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign origin_x = fld(inv_translation, 2'd0);
  assign origin_y = fld(inv_translation, 2'd1);
  assign origin_z = fld(inv_translation, 2'd2);

  // Advance everything unless a finished ray is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic [FRONT-1:0] fv;
  always_ff @(posedge clk) begin
    if (rst) fv <= '0;
    else if (adv) fv <= {fv[FRONT-2:0], in_valid};
  end

  // Stage 1: (2p+1) * pixel_size
  logic [PROD_W-1:0] px_prod, py_prod;
  always_ff @(posedge clk) begin
    if (adv) begin
      px_prod <= PROD_W'({pixel_x, 1'b1}) * PROD_W'(pixel_size);
      py_prod <= PROD_W'({pixel_y, 1'b1}) * PROD_W'(pixel_size);
    end
  end

  // Stage 2: round offset to Q.12 and subtract from the half extent
  logic [PROD_W:0]         rnd_x, rnd_y;
  logic signed [WW-1:0]    wx, wy;
  assign rnd_x = {1'b0, px_prod} + (PROD_W+1)'(256);
  assign rnd_y = {1'b0, py_prod} + (PROD_W+1)'(256);
  always_ff @(posedge clk) begin
    if (adv) begin
      wx <= $signed(WW'(half_width)) - $signed(WW'(rnd_x[PROD_W:9]));
      wy <= $signed(WW'(half_height)) - $signed(WW'(rnd_y[PROD_W:9]));
    end
  end

  // Stage 3: linear part products
  logic [CFG_DATA_W-1:0]    rows [3];
  logic signed [PRD_W-1:0]  mprod [3][2];
  logic signed [D_W-1:0]    mconst [3];
  assign rows[0] = inv_row_x;
  assign rows[1] = inv_row_y;
  assign rows[2] = inv_row_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        mprod[r][0] <= PRD_W'(fld(rows[r], 2'd0)) * PRD_W'(wx);
        mprod[r][1] <= PRD_W'(fld(rows[r], 2'd1)) * PRD_W'(wy);
        mconst[r]   <= D_W'(fld(rows[r], 2'd2)) <<< 12;
      end
    end
  end

  // Stage 4: direction components, split into sign and magnitude
  logic signed [D_W-1:0] dsum [3];
  logic [MAG_W-1:0]      mag_d [3];
  logic [2:0]            neg_d;
  always_comb begin
    for (int r = 0; r < 3; r++)
      dsum[r] = D_W'(mprod[r][0]) + D_W'(mprod[r][1]) - mconst[r];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        neg_d[r] <= dsum[r][D_W-1];
        mag_d[r] <= dsum[r][D_W-1] ? MAG_W'(-dsum[r]) : MAG_W'(dsum[r]);
      end
    end
  end

  // Stage 5: leading one per byte of the OR of all magnitudes
  logic [GRP*8-1:0]  ored;
  logic [GRP-1:0]    grp_any_next;
  logic [2:0]        grp_pos_next [GRP];
  logic [MAG_W-1:0]  mag_a [3];
  logic [2:0]        neg_a;
  logic [GRP-1:0]    grp_any;
  logic [2:0]        grp_pos [GRP];
  always_comb begin
    ored = (GRP*8)'(mag_d[0] | mag_d[1] | mag_d[2]);
    for (int g = 0; g < GRP; g++) begin
      grp_any_next[g] = |ored[g*8 +: 8];
      grp_pos_next[g] = '0;
      for (int b = 0; b < 8; b++)
        if (ored[g*8+b]) grp_pos_next[g] = 3'(b);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_a   <= mag_d;
      neg_a   <= neg_d;
      grp_any <= grp_any_next;
      grp_pos <= grp_pos_next;
    end
  end

  // Stage 6: pick the highest nonzero byte
  logic [PS_W-1:0]  lead_next, lead_pos;
  logic [MAG_W-1:0] mag_b [3];
  logic [2:0]       neg_b;
  logic             zero_b;
  always_comb begin
    lead_next = '0;
    for (int g = 0; g < GRP; g++)
      if (grp_any[g]) lead_next = {GRP_W'(g), grp_pos[g]};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_b    <= mag_a;
      neg_b    <= neg_a;
      lead_pos <= lead_next;
      zero_b   <= !(|grp_any);
    end
  end

  // Stage 7: shift so the largest magnitude has its top bit at NORM_TOP
  logic [MAG_W+NORM_TOP-1:0] shifted [3];
  logic [NORM_W-1:0]         nm_c [3];
  logic [2:0]                neg_c;
  logic                      zero_c;
  always_comb begin
    for (int r = 0; r < 3; r++)
      shifted[r] = {mag_b[r], {NORM_TOP{1'b0}}} >> lead_pos;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) nm_c[r] <= shifted[r][NORM_W-1:0];
      neg_c  <= neg_b;
      zero_c <= zero_b;
    end
  end

  // Stage 8: squares
  logic [2*NORM_W-1:0] sqr [3];
  logic [NORM_W-1:0]   nm_e [3];
  logic [2:0]          neg_e;
  logic                zero_e;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) sqr[r] <= (2*NORM_W)'(nm_c[r]) * (2*NORM_W)'(nm_c[r]);
      nm_e   <= nm_c;
      neg_e  <= neg_c;
      zero_e <= zero_c;
    end
  end

  // Square root chain: entry 0 is the sum stage, then one root bit per stage
  logic [SUM_W-1:0]  sq_n    [SQ_STEPS+1];
  logic [ROOT_W-1:0] sq_rt   [SQ_STEPS+1];
  logic [REM_W-1:0]  sq_rm   [SQ_STEPS+1];
  logic [NORM_W-1:0] sq_nm   [SQ_STEPS+1][3];
  logic [2:0]        sq_neg  [SQ_STEPS+1];
  logic              sq_zero [SQ_STEPS+1];
  logic              sq_v    [SQ_STEPS+1];
  logic [REM_W-1:0]  sq_r_next  [SQ_STEPS];
  logic [REM_W-1:0]  sq_t_next  [SQ_STEPS];
  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_r_next[k] = {sq_rm[k][REM_W-3:0], sq_n[k][SUM_W-1 -: 2]};
      sq_t_next[k] = REM_W'({sq_rt[k], 2'b01});
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_STEPS; k++) sq_v[k] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= fv[FRONT-1];
      for (int k = 0; k < SQ_STEPS; k++) sq_v[k+1] <= sq_v[k];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n[0]    <= SUM_W'(sqr[0]) + SUM_W'(sqr[1]) + SUM_W'(sqr[2]);
      sq_rt[0]   <= '0;
      sq_rm[0]   <= '0;
      sq_nm[0]   <= nm_e;
      sq_neg[0]  <= neg_e;
      sq_zero[0] <= zero_e;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_n[k+1]    <= sq_n[k] << 2;
        sq_nm[k+1]   <= sq_nm[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_zero[k+1] <= sq_zero[k];
        if (sq_r_next[k] >= sq_t_next[k]) begin
          sq_rm[k+1] <= sq_r_next[k] - sq_t_next[k];
          sq_rt[k+1] <= {sq_rt[k][ROOT_W-2:0], 1'b1};
        end else begin
          sq_rm[k+1] <= sq_r_next[k];
          sq_rt[k+1] <= {sq_rt[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Division chain: (mag * 2^17 + len) / (2 * len), one quotient bit per stage
  logic [NUM_W-1:0]  num_next [3];
  logic [DREM_W-1:0] dv_rem  [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_lo   [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_q    [QUO_W+1][3];
  logic [DEN_W-1:0]  dv_den  [QUO_W+1];
  logic [2:0]        dv_neg  [QUO_W+1];
  logic              dv_zero [QUO_W+1];
  logic              dv_v    [QUO_W+1];
  logic [DREM_W-1:0] dv_r_next [QUO_W][3];
  always_comb begin
    for (int r = 0; r < 3; r++)
      num_next[r] = (NUM_W'(sq_nm[SQ_STEPS][r]) << QUO_W) + NUM_W'(sq_rt[SQ_STEPS]);
    for (int k = 0; k < QUO_W; k++)
      for (int r = 0; r < 3; r++)
        dv_r_next[k][r] = {dv_rem[k][r][DREM_W-2:0], dv_lo[k][r][QUO_W-1]};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) dv_v[k] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQ_STEPS];
      for (int k = 0; k < QUO_W; k++) dv_v[k+1] <= dv_v[k];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_den[0]  <= {sq_rt[SQ_STEPS], 1'b0};
      dv_neg[0]  <= sq_neg[SQ_STEPS];
      dv_zero[0] <= sq_zero[SQ_STEPS];
      for (int r = 0; r < 3; r++) begin
        dv_rem[0][r] <= DREM_W'(num_next[r][NUM_W-1:QUO_W]);
        dv_lo[0][r]  <= num_next[r][QUO_W-1:0];
        dv_q[0][r]   <= '0;
      end
      for (int k = 0; k < QUO_W; k++) begin
        dv_den[k+1]  <= dv_den[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_zero[k+1] <= dv_zero[k];
        for (int r = 0; r < 3; r++) begin
          dv_lo[k+1][r] <= dv_lo[k][r] << 1;
          if (dv_r_next[k][r] >= DREM_W'(dv_den[k])) begin
            dv_rem[k+1][r] <= dv_r_next[k][r] - DREM_W'(dv_den[k]);
            dv_q[k+1][r]   <= {dv_q[k][r][QUO_W-2:0], 1'b1};
          end else begin
            dv_rem[k+1][r] <= dv_r_next[k][r];
            dv_q[k+1][r]   <= {dv_q[k][r][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output register: restore signs, force zero on a degenerate ray
  logic signed [DIR_W-1:0] dir_next [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (dv_zero[QUO_W])
        dir_next[r] = '0;
      else if (dv_neg[QUO_W][r])
        dir_next[r] = -$signed(DIR_W'(dv_q[QUO_W][r]));
      else
        dir_next[r] = $signed(DIR_W'(dv_q[QUO_W][r]));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_v[QUO_W];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x      <= dir_next[0];
      dir_y      <= dir_next[1];
      dir_z      <= dir_next[2];
      degenerate <= dv_zero[QUO_W];
    end
  end

  // Checks
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> dir_x == 0 && dir_y == 0 && dir_z == 0)
    else $error("degenerate ray with nonzero direction");

  a_dir_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> dir_x != 0 || dir_y != 0 || dir_z != 0)
    else $error("normalized direction lost all components");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQ_STEPS] && !sq_zero[SQ_STEPS] |-> sq_rt[SQ_STEPS][ROOT_W-1:NORM_TOP] != 0)
    else $error("vector length below normalized range");

  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    dv_v[QUO_W] && !dv_zero[QUO_W] |->
      dv_q[QUO_W][0] <= QUO_W'(ONE_Q16) && dv_q[QUO_W][1] <= QUO_W'(ONE_Q16) &&
      dv_q[QUO_W][2] <= QUO_W'(ONE_Q16))
    else $error("direction component above one");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input held without output back pressure");

endmodule
